/* rtl/spq_pkg.sv */
package spq_pkg;

    // Fixed field widths of the word on each channel
    localparam int KEY_PORT_WIDTH   = 16;
    localparam int COUNT_PORT_WIDTH = 4;
    localparam int STATUS_WIDTH     = 2;

    localparam int DEFAULT_DEPTH     = 8;
    localparam int DEFAULT_KEY_WIDTH = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic en;      // a word is accepted and will change the array
        logic insert;  // 1 insert, 0 remove
    } cell_ctrl_t;

endpackage

/* rtl/sorted_array_priority_queue.sv */
// Sorted-array priority queue built as a row of DEPTH compare-and-shift cells.
// The result word is registered in the cycle after the command word is taken.
// Throughput: one command per cycle while the result slot is free or being emptied; every cell
// compares and shifts in parallel, so the row and the count register update together.
// Reset (aresetn, synchronous, active low) empties the queue and drops m_valid;
// the cell keys are left as they are and only slots below the count are read.
module sorted_array_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEFAULT_DEPTH,
    parameter int KEY_WIDTH = spq_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // command channel
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_command,
    input  logic signed [spq_pkg::KEY_PORT_WIDTH-1:0] s_key,
    // result channel
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [spq_pkg::KEY_PORT_WIDTH-1:0] m_head_key,
    output logic                                      m_head_valid,
    output logic [spq_pkg::COUNT_PORT_WIDTH-1:0]      m_entry_count,
    output logic [spq_pkg::STATUS_WIDTH-1:0]          m_status
);

    localparam int CW = $clog2(DEPTH + 1);

    // Entry count of the queue
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Output register: parts the command side from the result side
    logic                                      m_valid_reg;
    logic                                      m_valid_next;
    logic signed [spq_pkg::KEY_PORT_WIDTH-1:0] m_head_key_reg;
    logic                                      m_head_valid_reg;
    logic [spq_pkg::COUNT_PORT_WIDTH-1:0]      m_entry_count_reg;
    spq_pkg::status_t                          m_status_reg;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        is_insert;
    spq_pkg::status_t            status_now;
    spq_pkg::cell_ctrl_t         ctrl;
    logic signed [KEY_WIDTH-1:0] new_key;

    logic                        cell_ge   [DEPTH];
    logic signed [KEY_WIDTH-1:0] cell_key  [DEPTH];
    logic signed [KEY_WIDTH-1:0] cell_next [DEPTH];

    // Ready while the result slot is free or being emptied this cycle
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign is_insert = (s_command == spq_pkg::CMD_INSERT);

    // Key taken at KEY_WIDTH bits and sign-extended (or truncated)
    assign new_key = KEY_WIDTH'(s_key);

    // Refused words leave the array and count untouched
    always_comb begin
        status_now = spq_pkg::STATUS_DONE;
        if (is_insert && full) begin
            status_now = spq_pkg::STATUS_FULL;
        end else if (!is_insert && empty) begin
            status_now = spq_pkg::STATUS_EMPTY;
        end
    end

    assign ctrl.en     = accept && (status_now == spq_pkg::STATUS_DONE);
    assign ctrl.insert = is_insert;

    always_comb begin
        count_next = count_reg;
        if (ctrl.en) begin
            count_next = is_insert ? count_reg + 1'b1 : count_reg - 1'b1;
        end
    end

    // The row: each cell sees its left neighbour for an insert shift and
    // its right neighbour for a remove shift. The head cell takes the new
    // key when it is empty or its own key is smaller; the tail cell refills from itself.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                        left_ge;
        logic signed [KEY_WIDTH-1:0] left_key;
        logic signed [KEY_WIDTH-1:0] right_key;

        if (i == 0) begin : g_head
            assign left_ge  = 1'b1;
            assign left_key = new_key;
        end else begin : g_body
            assign left_ge  = cell_ge[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_key = cell_key[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
        end

        spq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (CW'(i) < count_reg),
            .new_key   (new_key),
            .left_ge   (left_ge),
            .left_key  (left_key),
            .right_key (right_key),
            .ge        (cell_ge[i]),
            .key       (cell_key[i]),
            .key_next  (cell_next[i])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result word reflects the queue after the step
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_head_valid_reg  <= (count_next != '0);
            m_head_key_reg    <= (count_next != '0)
                                 ? spq_pkg::KEY_PORT_WIDTH'(cell_next[0]) : '0;
            m_entry_count_reg <= spq_pkg::COUNT_PORT_WIDTH'(count_next);
            m_status_reg      <= status_now;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_head_key    = m_head_key_reg;
    assign m_head_valid  = m_head_valid_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_status      = m_status_reg;

endmodule

/* rtl/spq_cell.sv */
module spq_cell #(
    parameter int KEY_WIDTH = spq_pkg::DEFAULT_KEY_WIDTH
) (
    input  logic                        aclk,
    input  spq_pkg::cell_ctrl_t         ctrl,
    input  logic                        occupied,
    input  logic signed [KEY_WIDTH-1:0] new_key,
    input  logic                        left_ge,
    input  logic signed [KEY_WIDTH-1:0] left_key,
    input  logic signed [KEY_WIDTH-1:0] right_key,
    output logic                        ge,
    output logic signed [KEY_WIDTH-1:0] key,
    output logic signed [KEY_WIDTH-1:0] key_next
);

    logic signed [KEY_WIDTH-1:0] key_reg;

    // Holds a key that stays ahead of the new one (ties keep arrival order)
    assign ge = occupied && (key_reg >= new_key);

    always_comb begin
        key_next = key_reg;
        if (ctrl.en) begin
            if (ctrl.insert) begin
                if (!ge) begin
                    key_next = left_ge ? new_key : left_key;
                end
            end else begin
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

/* rtl/spq_checker.sv */
module spq_checker (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      m_valid,
    input logic                                      m_ready,
    input logic signed [spq_pkg::KEY_PORT_WIDTH-1:0] m_head_key,
    input logic                                      m_head_valid,
    input logic [spq_pkg::COUNT_PORT_WIDTH-1:0]      m_entry_count,
    input logic [spq_pkg::STATUS_WIDTH-1:0]          m_status
);

    // Result word held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_head_key)
                                   && $stable(m_status) && $stable(m_entry_count)))
        else $error("result word changed while stalled");

    // No result word straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    // An empty queue reports a zero head key
    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_head_valid) |-> (m_head_key == '0))
        else $error("head key not zero on empty queue");

    // A refused remove means the queue was and stays empty
    a_empty_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == spq_pkg::STATUS_EMPTY) |-> !m_head_valid)
        else $error("remove refused but queue not empty");

    // A refused insert means the queue is full, so not empty
    a_full_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == spq_pkg::STATUS_FULL) |-> m_head_valid)
        else $error("insert refused but queue empty");

endmodule

bind sorted_array_priority_queue spq_checker u_spq_checker (.*);

/* dv/tb_sorted_array_priority_queue.sv */
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = DEFAULT_DEPTH;
    localparam int KEY_W       = KEY_PORT_WIDTH;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 16;

    // Expected content of one result word
    typedef struct {
        logic signed [KEY_W-1:0]        head_key;
        logic                           head_valid;
        logic [COUNT_PORT_WIDTH-1:0]    entry_count;
        status_t                        status;
    } queue_result_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic                              s_command = CMD_INSERT;
    logic signed [KEY_W-1:0]           s_key = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [KEY_W-1:0]           m_head_key;
    logic                              m_head_valid;
    logic [COUNT_PORT_WIDTH-1:0]       m_entry_count;
    logic [STATUS_WIDTH-1:0]           m_status;

    // Shadow of the queue contents, largest key first
    logic signed [KEY_W-1:0]           held_keys [QUEUE_DEPTH];
    int                                held_count = 0;

    queue_result_t                     pending_results [$];
    queue_result_t                     expected_word;
    int                                error_count = 0;
    int                                cycle_count = 0;

    // Idling switches, flipped per test
    bit                                send_idle_en  = 1'b1;
    bit                                ready_idle_en = 1'b1;
    int                                ready_hold    = 0;

    sorted_array_priority_queue u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_head_key    (m_head_key),
        .m_head_valid  (m_head_valid),
        .m_entry_count (m_entry_count),
        .m_status      (m_status)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the shadow queue by one command and return the word it should yield
    function automatic queue_result_t step_queue_model(command_t cmd,
                                                       logic signed [KEY_W-1:0] key);
        queue_result_t r;
        int            pos;
        r.status = STATUS_DONE;
        if (cmd == CMD_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                // walk past every key that is greater or equal, so ties keep arrival order
                pos = held_count;
                while (pos > 0 && held_keys[pos-1] < key) begin
                    held_keys[pos] = held_keys[pos-1];
                    pos--;
                end
                held_keys[pos] = key;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                for (int i = 0; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
                held_count--;
            end
        end
        r.head_valid  = (held_count > 0);
        r.head_key    = (held_count > 0) ? held_keys[0] : '0;
        r.entry_count = held_count[COUNT_PORT_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    // Offer one command word; predicted on acceptance.
    // Valid is only dropped when a gap is taken, so it never toggles within a step.
    task automatic send_word(input command_t cmd, input logic signed [KEY_W-1:0] key);
        int gap;
        gap = send_idle_en ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(step_queue_model(cmd, key));
    endtask

    // Key mix: extremes, a narrow band for ties, copies of stored keys, plain random
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return KEY_W'($signed($urandom_range(0, 6)) - 3);
            4: begin
                if (held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
                return KEY_W'($urandom);
            end
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Receiver: drops ready for random spells, driven at the falling edge
    initial begin
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                ready_hold--;
                m_ready <= 1'b0;
            end else if (ready_idle_en) begin
                ready_hold = pick_gap();
                m_ready <= (ready_hold == 0);
                if (ready_hold > 0) ready_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: each accepted word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                expected_word = pending_results.pop_front();
                check_field("head_key", m_head_key, expected_word.head_key);
                check_field("head_valid", m_head_valid, expected_word.head_valid);
                check_field("entry_count", m_entry_count, expected_word.entry_count);
                check_field("status", m_status, expected_word.status);
            end
        end
    end

    // Removes on an empty queue are refused; the key must not matter
    task automatic test_remove_when_empty();
        send_word(CMD_REMOVE, 16'sh7fff);
        send_word(CMD_REMOVE, 16'sh8000);
    endtask

    // Fill with extremes and ties, overfill, then drain past empty
    task automatic test_fill_and_drain();
        send_word(CMD_INSERT, 16'sh0000);
        send_word(CMD_INSERT, 16'sh8000);
        send_word(CMD_INSERT, 16'sh7fff);
        send_word(CMD_INSERT, 16'shffff);
        send_word(CMD_INSERT, 16'sh0001);
        send_word(CMD_INSERT, 16'sh7fff);
        send_word(CMD_INSERT, 16'sh8000);
        send_word(CMD_INSERT, 16'sh5555);
        // full now: both of these bounce
        send_word(CMD_INSERT, 16'shaaaa);
        send_word(CMD_INSERT, 16'sh7fff);
        repeat (QUEUE_DEPTH) send_word(CMD_REMOVE, 16'shaaaa);
        send_word(CMD_REMOVE, 16'sh5555);
    endtask

    // Random traffic, biased so the fill level drifts across its whole range
    task automatic test_random_traffic(input int n_words, input int insert_pct,
                                       input bit idle_en);
        command_t cmd;
        send_idle_en  = idle_en;
        ready_idle_en = idle_en;
        for (int i = 0; i < n_words; i++) begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_word(cmd, pick_key());
        end
        send_idle_en  = 1'b1;
        ready_idle_en = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < QUEUE_DEPTH; i++) held_keys[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_remove_when_empty();
        test_fill_and_drain();
        test_random_traffic(300, 50, 1'b1);
        test_random_traffic(250, 80, 1'b1);
        test_random_traffic(250, 20, 1'b1);
        test_random_traffic(300, 60, 1'b0);   // back to back, no idling at all
        test_random_traffic(250, 40, 1'b1);
        test_random_traffic(200, 85, 1'b0);
        test_random_traffic(250, 50, 1'b1);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results still expected at end of run");

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_array_priority_queue.sv
rtl/spq_checker.sv
dv/tb_sorted_array_priority_queue.sv
